### design/ide_pkg.sv
// Shared constants, types and helper functions of the infix digit expression evaluator.
`default_nettype none

package ide_pkg;

  localparam int DEFAULT_STACK_DEPTH = 8;

  localparam logic [7:0] SYM_ZERO = 8'h30;
  localparam logic [7:0] SYM_NINE = 8'h39;
  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SYMBOL    = 2'd1,
    ST_DIVZERO   = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  // Which stack entry a read fetches: relative to the fill count, or the base entry.
  typedef enum logic [1:0] {
    RD_TOP  = 2'd0,
    RD_OPER = 2'd1,
    RD_LOW  = 2'd2,
    RD_BASE = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    latch_in;
    logic    push;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_op;
    logic    cap_b;
    logic    cap_a;
    logic    alu_start;
    logic    wr_result;
    logic    clr_count;
    logic    load_out;
    status_t out_status;
  } ide_cmd_t;

  typedef struct packed {
    logic sym_digit;
    logic sym_op;
    logic cnt_ge3;
    logic cnt_full;
    logic cnt_zero;
    logic rank_ge;
    logic alu_done;
    logic div_zero;
    logic out_free;
  } ide_sts_t;

  function automatic logic is_digit(input logic [7:0] sym);
    is_digit = (sym >= SYM_ZERO) && (sym <= SYM_NINE);
  endfunction

  function automatic logic is_operator(input logic [7:0] sym);
    is_operator = (sym == SYM_ADD) || (sym == SYM_SUB) || (sym == SYM_MUL) || (sym == SYM_DIV);
  endfunction

  // Multiply and divide bind tighter than add and subtract.
  function automatic logic rank(input logic [7:0] sym);
    rank = (sym == SYM_MUL) || (sym == SYM_DIV);
  endfunction

endpackage

`default_nettype wire

### design/infix_digit_expression_evaluator.sv
// Top level of the infix digit expression evaluator: controller, datapath and checks.
//
// The input channel carries one ASCII character per beat (in_symbol) with in_last
// marking the final character of an expression. Digits 0-9 and the operators
// + - * / must alternate; * and / bind tighter than + and -, equal ranks apply
// left to right, and all values are signed 8-bit with wrap-around.
// The result channel gives one beat per expression, on the character flagged
// last: out_value (zero when out_status is not OK) and out_status (OK, unknown
// symbol, divide by zero or malformed expression; the first error wins).
// Items are processed one at a time, and in_stall is high while one is in work.
// A digit is decoded and pushed before the next character is accepted. An operator
// is checked against the stack and pushed after the reductions it triggers; each
// reduction reads operator and operands, runs the arithmetic and writes the result
// back, and a divide runs one quotient bit a cycle. The last character's result is
// registered after any reductions it triggers, and the next beat can be taken as
// soon as the result is registered.
// Reset clears the stack count, error and alternation state; the stack memory
// itself is not cleared. The result sits in an output register, so a stalled
// receiver holds up the input only once the next result is ready to be loaded.
`default_nettype none

module infix_digit_expression_evaluator
  import ide_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_symbol,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_value,
  output logic [1:0]      out_status
);

  ide_cmd_t cmd;
  ide_sts_t sts;

  // The controller decides; the datapath holds the stack and does the arithmetic.
  ide_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ide_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_symbol  (in_symbol),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

  // A new result must never overwrite one the receiver has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result loaded over an untaken result beat");

  // An error result always carries a zero value.
  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_value == 8'd0))
    else $error("error result with nonzero value");

  // In the cycle after a character is accepted, the block is still busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second character accepted back to back");

endmodule

`default_nettype wire

### design/ide_div.sv
// Iterative 8-bit unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module ide_div
  import ide_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [7:0] dividend,
  input  wire logic [7:0] divisor,
  output logic            done,
  output logic [7:0]      quotient
);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] step_r, step_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [7:0] dvs_r, dvs_nxt;
  logic [8:0] rem_sh;
  logic       fits;

  assign rem_sh = {rem_r, quo_r[7]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 3'd0;
      rem_nxt  = 8'd0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? 8'(rem_sh - {1'b0, dvs_r}) : rem_sh[7:0];
      quo_nxt  = {quo_r[6:0], fits};
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### design/ide_dp.sv
// Datapath: symbol register, operand stack memory, arithmetic unit and result register.
`default_nettype none

module ide_dp
  import ide_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_symbol,
  input  wire ide_cmd_t   cmd,
  output ide_sts_t        sts,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_value,
  output logic [1:0]      out_status
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [7:0]       stack_mem [STACK_DEPTH];
  logic [7:0]       rd_data_r;
  logic [7:0]       sym_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       op_r, a_r, b_r;
  logic             out_valid_r;
  logic [7:0]       out_value_r;
  logic [1:0]       out_status_r;

  logic [CNT_W-1:0]  rd_cnt;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] push_addr;
  logic [CNT_W-1:0]  low_cnt;
  logic [ADDR_W-1:0] res_addr;
  logic [7:0]        push_data;
  logic [7:0]        result;
  logic signed [15:0] prod;
  logic [7:0]        mag_a, mag_b, quo, quo_signed;
  logic              op_is_div, div_done;

  // Address of a read, taken relative to the fill count except for the base entry.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_TOP:  rd_cnt = count_r - CNT_W'(1);
      RD_OPER: rd_cnt = count_r - CNT_W'(2);
      RD_LOW:  rd_cnt = count_r - CNT_W'(3);
      RD_BASE: rd_cnt = '0;
      default: rd_cnt = '0;
    endcase
  end

  assign rd_addr   = rd_cnt[ADDR_W-1:0];
  assign push_addr = count_r[ADDR_W-1:0];
  assign low_cnt   = count_r - CNT_W'(3);
  assign res_addr  = low_cnt[ADDR_W-1:0];
  assign push_data = is_digit(sym_r) ? 8'(sym_r - SYM_ZERO) : sym_r;

  // Arithmetic on the captured operands.
  assign op_is_div  = (op_r == SYM_DIV);
  assign prod       = $signed(a_r) * $signed(b_r);
  assign mag_a      = a_r[7] ? 8'(-a_r) : a_r;
  assign mag_b      = b_r[7] ? 8'(-b_r) : b_r;
  assign quo_signed = (a_r[7] ^ b_r[7]) ? 8'(-quo) : quo;

  ide_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.alu_start && op_is_div),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    case (op_r)
      SYM_ADD: result = a_r + b_r;
      SYM_SUB: result = a_r - b_r;
      SYM_MUL: result = prod[7:0];
      default: result = (b_r == 8'd0) ? 8'd0 : quo_signed;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr_count) begin
      count_nxt = '0;
    end else if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.wr_result) begin
      count_nxt = count_r - CNT_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[push_addr] <= push_data;
    end else if (cmd.wr_result) begin
      stack_mem[res_addr] <= result;
    end
    if (cmd.rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.latch_in) begin
      sym_r <= in_symbol;
    end
    if (cmd.cap_op) begin
      op_r <= rd_data_r;
    end
    if (cmd.cap_b) begin
      b_r <= rd_data_r;
    end
    if (cmd.cap_a) begin
      a_r <= rd_data_r;
    end
    if (cmd.load_out) begin
      out_value_r  <= (cmd.out_status == ST_OK) ? rd_data_r : 8'd0;
      out_status_r <= cmd.out_status;
    end
  end

  always_comb begin
    sts.sym_digit = is_digit(sym_r);
    sts.sym_op    = is_operator(sym_r);
    sts.cnt_ge3   = count_r >= CNT_W'(3);
    sts.cnt_full  = count_r >= CNT_W'(STACK_DEPTH);
    sts.cnt_zero  = count_r == '0;
    sts.rank_ge   = rank(rd_data_r) || !rank(sym_r);
    sts.alu_done  = op_is_div ? div_done : 1'b1;
    sts.div_zero  = op_is_div && (b_r == 8'd0);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

### design/ide_ctrl.sv
// Controller: sequences decoding, shift-reduce steps and result delivery.
`default_nettype none

module ide_ctrl
  import ide_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_stall,
  input  wire ide_sts_t sts,
  output ide_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_RD_OP,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_WAIT,
    S_PUSHOP,
    S_FINISH,
    S_RES,
    S_RD_RES
  } state_t;

  state_t  state_r, state_nxt;
  status_t err_r, err_nxt;
  logic    expect_r, expect_nxt;
  logic    last_r, last_nxt;
  logic    final_r, final_nxt;
  status_t err_end;

  assign err_end = (err_r == ST_OK && (expect_r || sts.cnt_zero)) ? ST_MALFORMED : err_r;

  always_comb begin
    state_nxt      = state_r;
    err_nxt        = err_r;
    expect_nxt     = expect_r;
    last_nxt       = last_r;
    final_nxt      = final_r;
    cmd            = '0;
    cmd.rd_sel     = RD_BASE;
    cmd.out_status = err_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          last_nxt     = in_last;
          final_nxt    = 1'b0;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = last_r ? S_FINISH : S_IDLE;
        if (err_r == ST_OK) begin
          if (sts.sym_digit) begin
            if (!expect_r) begin
              err_nxt = ST_MALFORMED;
            end else begin
              if (sts.cnt_full) begin
                err_nxt = ST_MALFORMED;
              end else begin
                cmd.push = 1'b1;
              end
              expect_nxt = 1'b0;
            end
          end else if (sts.sym_op) begin
            if (expect_r) begin
              err_nxt = ST_MALFORMED;
            end else begin
              state_nxt = S_CHECK;
            end
          end else begin
            err_nxt = ST_SYMBOL;
          end
        end
      end
      S_CHECK: begin
        if (sts.cnt_ge3) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_OPER;
          state_nxt  = S_RD_OP;
        end else begin
          state_nxt = final_r ? S_RES : S_PUSHOP;
        end
      end
      S_RD_OP: begin
        if (final_r || sts.rank_ge) begin
          cmd.cap_op = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TOP;
          state_nxt  = S_RD_B;
        end else begin
          state_nxt = S_PUSHOP;
        end
      end
      S_RD_B: begin
        cmd.cap_b  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LOW;
        state_nxt  = S_RD_A;
      end
      S_RD_A: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.alu_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (sts.alu_done) begin
          cmd.wr_result = 1'b1;
          if (sts.div_zero) begin
            err_nxt   = ST_DIVZERO;
            state_nxt = last_r ? S_FINISH : S_IDLE;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_PUSHOP: begin
        if (sts.cnt_full) begin
          err_nxt = ST_MALFORMED;
        end else begin
          cmd.push   = 1'b1;
          expect_nxt = 1'b1;
        end
        state_nxt = last_r ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        err_nxt = err_end;
        if (err_end != ST_OK) begin
          state_nxt = S_RES;
        end else begin
          final_nxt = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_RES: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BASE;
        state_nxt  = S_RD_RES;
      end
      S_RD_RES: begin
        if (sts.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.clr_count = 1'b1;
          err_nxt       = ST_OK;
          expect_nxt    = 1'b1;
          final_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      err_r    <= ST_OK;
      expect_r <= 1'b1;
      last_r   <= 1'b0;
      final_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      err_r    <= err_nxt;
      expect_r <= expect_nxt;
      last_r   <= last_nxt;
      final_r  <= final_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

### bench/tb_infix_digit_expression_evaluator.sv
// Self-checking testbench for the infix digit expression evaluator, with its own predictor.
`default_nettype none

module tb_infix_digit_expression_evaluator;
  import ide_pkg::*;

  localparam int DEPTH        = DEFAULT_STACK_DEPTH;
  // The slowest legal run stays well below this. Add the gaps of both sides and
  // the total is still far short.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DIRECTED     = 25;
  localparam int STEADY_ITEMS = 250;
  localparam int RANDOM_ITEMS = 1175;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [7:0] value;
    status_t    status;
  } outcome_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_symbol;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_value;
  logic [1:0] out_status;

  // When quiet is set, neither side inserts gaps or stalls.
  bit quiet;
  int items_sent;
  int fail_count;
  int cycle_count;

  // Results still owed by the block, oldest first.
  outcome_t expected_outcomes[$];

  // Shadow copy of the evaluator's state. The stack holds values and operator
  // codes in turn.
  logic [7:0] calc_stack [DEPTH];
  int         calc_count;
  status_t    calc_error;
  bit         calc_want_digit;

  infix_digit_expression_evaluator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_symbol (in_symbol),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver stalls at random on the falling edge. The stall is then
  // stable when the block samples it at the rising edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !quiet && ($urandom_range(0, 99) < 17);
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Multiply and divide bind tighter than add and subtract.
  function automatic bit tight(input logic [7:0] sym);
    return (sym == SYM_MUL) || (sym == SYM_DIV);
  endfunction

  // Only the first error of an expression is kept.
  function automatic void calc_flag(input status_t code);
    if (calc_error == ST_OK)
      calc_error = code;
  endfunction

  function automatic void calc_clear();
    calc_count      = 0;
    calc_error      = ST_OK;
    calc_want_digit = 1'b1;
  endfunction

  function automatic void calc_push(input logic [7:0] v);
    if (calc_count >= DEPTH) begin
      calc_flag(ST_MALFORMED);
    end else begin
      calc_stack[calc_count] = v;
      calc_count++;
    end
  endfunction

  // Fold value, operator, value at the top of the stack into one value.
  // The result is worked out at integer width and then cut to eight bits, so it
  // wraps. Integer division already truncates toward zero.
  function automatic void calc_reduce();
    int         lhs;
    int         rhs;
    int         res;
    logic [7:0] op;
    if (calc_count < 3)
      return;
    rhs = $signed(calc_stack[calc_count-1]);
    op  = calc_stack[calc_count-2];
    lhs = $signed(calc_stack[calc_count-3]);
    res = 0;
    case (op)
      SYM_ADD: res = lhs + rhs;
      SYM_SUB: res = lhs - rhs;
      SYM_MUL: res = lhs * rhs;
      default: begin
        if (rhs == 0)
          calc_flag(ST_DIVZERO);
        else
          res = lhs / rhs;
      end
    endcase
    calc_count -= 2;
    calc_stack[calc_count-1] = 8'(res);
  endfunction

  // Apply one accepted character. Returns 1 with the outcome on the last one.
  function automatic bit calc_symbol(input logic [7:0] sym, input bit last,
                                     output outcome_t res);
    res = '0;
    if (calc_error == ST_OK) begin
      if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
        if (!calc_want_digit) begin
          calc_flag(ST_MALFORMED);
        end else begin
          calc_push(sym - SYM_ZERO);
          calc_want_digit = 1'b0;
        end
      end else if (sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL || sym == SYM_DIV) begin
        if (calc_want_digit) begin
          calc_flag(ST_MALFORMED);
        end else begin
          // Left to right: reduce everything of equal or tighter binding first.
          while (calc_error == ST_OK && calc_count >= 3 &&
                 tight(calc_stack[calc_count-2]) >= tight(sym))
            calc_reduce();
          if (calc_error == ST_OK) begin
            calc_push(sym);
            calc_want_digit = 1'b1;
          end
        end
      end else begin
        calc_flag(ST_SYMBOL);
      end
    end
    if (!last)
      return 1'b0;
    // An expression that ends on an operator, or is empty, is malformed.
    if (calc_error == ST_OK && (calc_want_digit || calc_count == 0))
      calc_flag(ST_MALFORMED);
    while (calc_error == ST_OK && calc_count >= 3)
      calc_reduce();
    res.status = calc_error;
    res.value  = (calc_error == ST_OK) ? calc_stack[0] : 8'h00;
    calc_clear();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Present one character from a falling edge. Valid stays high from that
  // edge until a rising edge with no stall accepts the beat. The random gaps
  // come before valid is raised, so valid gets one assignment per edge.
  task automatic send_char(input logic [7:0] sym, input bit last);
    outcome_t res;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_last   <= last;
    do @(posedge clk); while (in_stall);
    if (calc_symbol(sym, last, res))
      expected_outcomes.push_back(res);
    items_sent++;
  endtask

  // Send a whole expression. The final character carries last.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return SYM_ADD;
      1:       return SYM_SUB;
      2:       return SYM_MUL;
      default: return SYM_DIV;
    endcase
  endfunction

  // Most expressions are well formed, so that they reach deep into the
  // reductions. About one in five is corrupted in one of four ways: a random
  // byte in place of a character, a missing final digit, an extra random
  // byte, or a doubled character that breaks the alternation.
  task automatic send_random_expr();
    logic [7:0] chars[$];
    int         n_ops;
    int         pos;
    n_ops = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
    chars.push_back(SYM_ZERO + 8'($urandom_range(0, 9)));
    repeat (n_ops) begin
      chars.push_back(pick_operator());
      chars.push_back(SYM_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 99) < 20) begin
      pos = $urandom_range(0, chars.size() - 1);
      case ($urandom_range(0, 3))
        0: chars[pos] = 8'($urandom_range(0, 255));
        1: begin
          if (chars.size() > 1)
            void'(chars.pop_back());
          else
            chars[0] = pick_operator();
        end
        2:       chars.insert(pos, 8'($urandom_range(0, 255)));
        default: chars.insert(pos, chars[pos]);
      endcase
    end
    foreach (chars[i])
      send_char(chars[i], i == chars.size() - 1);
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  // Each accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d status %0d",
                 $time, $signed(out_value), out_status);
        fail_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (out_value !== want.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d",
                   $time, $signed(want.value), $signed(out_value));
          fail_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // The smallest legal expression is a single digit.
  task automatic test_single_digit();
    send_text("9");
  endtask

  // The product 729 wraps to -39. Halving it must truncate toward zero and
  // give -19. A run of subtractions must fold left to right and give -8.
  task automatic test_precedence_and_wrap();
    send_text("9*9*9/2");
    send_text("8-9-7");
  endtask

  task automatic test_divide_by_zero();
    send_text("0/0");
  endtask

  // Test both extremes of the symbol byte. The first bad byte decides the
  // status, and later characters are ignored.
  task automatic test_unknown_symbols();
    send_char("3", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("4", 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  // An operator alone, a trailing operator, and two digits in a row.
  task automatic test_malformed();
    send_text("+");
    send_text("3+");
    send_text("34");
  endtask

  // Back-to-back beats on both sides, so that the next expression streams in
  // while the output register still holds the last result.
  task automatic test_random_steady();
    quiet = 1'b1;
    while (items_sent < DIRECTED + STEADY_ITEMS)
      send_random_expr();
    quiet = 1'b0;
  endtask

  task automatic test_random_gaps();
    while (items_sent < DIRECTED + RANDOM_ITEMS)
      send_random_expr();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_symbol  = 8'h00;
    in_last    = 1'b0;
    quiet      = 1'b0;
    items_sent = 0;
    fail_count = 0;
    cycle_count = 0;
    calc_clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_digit();
    test_precedence_and_wrap();
    test_divide_by_zero();
    test_unknown_symbols();
    test_malformed();
    test_random_steady();
    test_random_gaps();

    @(negedge clk);
    in_valid <= 1'b0;
    // Drain the outstanding results. Then keep checking, so
    // that a stray extra beat would still be caught.
    while (expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
